FILE: rtl/sss_pkg.sv
// Package for the setpoint sequencer core: command and run-state codes,
// configuration register indexes and fixed sizes. No dependencies.
`default_nettype none

package sss_pkg;

    localparam int unsigned POINT_COUNT = 3;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RUN     = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_DONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_IDLE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_POINT_ZERO = 3'd0,
        REG_POINT_ONE  = 3'd1,
        REG_POINT_TWO  = 3'd2,
        REG_SLEW_STEP  = 3'd3,
        REG_TIMEOUT    = 3'd4,
        REG_ERR_LIMIT  = 3'd5,
        REG_SPD_LIMIT  = 3'd6,
        REG_HOLD_TIME  = 3'd7
    } t_reg_idx;

    localparam logic [31:0] TIMEOUT_RESET = 32'd4800;

endpackage

`default_nettype wire

FILE: rtl/setpoint_sequencer_slew_settle_core.sv
// Setpoint sequencer with slew-limited reference and settle/hold detection.
// Depends on sss_pkg for command, run-state and register index codes.
//
//  channel   direction  beat contents
//  s         in         tuser: cmd, meas_valid; tdata: now_time, position, speed
//  m         out        tdata: run_state, step_index, reference_pos,
//                              final_target, elapsed_time
//  apb       in/out     eight configuration registers at byte address 4*i
//
// Each beat passes an input register, one level of compare/update logic and
// the result register, from which its result is offered on m.
// One beat is accepted every cycle while the result side keeps taking beats.
// A stalled result register holds the input register, which then stalls s.
// Reset is synchronous and restores configuration, state and valid flags; data registers are not reset.
`default_nettype none

module setpoint_sequencer_slew_settle_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,  // now_time[31:0], position[47:32], speed[67:48]
    input  wire logic [2:0]  i_s_tuser,  // cmd[1:0], meas_valid[2]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,  // run_state[1:0], step_index[3:2],
                                         // reference_pos[19:4], final_target[35:20],
                                         // elapsed_time[67:36]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers.
    logic signed [15:0] r_point_zero, r_point_one, r_point_two;
    logic [14:0]        r_slew_step;
    logic [31:0]        r_timeout;
    logic [15:0]        r_err_limit;
    logic [18:0]        r_spd_limit;
    logic [31:0]        r_hold_time;

    // Input register.
    logic               r_in_valid;
    sss_pkg::t_cmd      r_cmd;
    logic [31:0]        r_now;
    logic               r_meas_valid;
    logic signed [15:0] r_pos;
    logic signed [19:0] r_spd;

    // Sequencer state.
    sss_pkg::t_mode     r_mode, n_mode;
    logic [1:0]         r_idx, n_idx;
    logic signed [15:0] r_dest, n_dest;
    logic signed [15:0] r_ref, n_ref;
    logic [31:0]        r_start, n_start;
    logic [31:0]        r_elapsed, n_elapsed;
    logic [31:0]        r_settle, n_settle;
    logic               r_settling, n_settling;

    // Result register.
    logic               r_out_valid;
    logic [71:0]        r_out_data;

    logic               w_advance;
    logic               w_cfg_wr;
    logic signed [16:0] w_diff;
    logic signed [16:0] w_step;
    logic               w_arrived;
    logic signed [15:0] w_slewed;
    logic signed [16:0] w_err;
    logic [16:0]        w_abs_err;
    logic [19:0]        w_abs_spd;
    logic [31:0]        w_run_time;
    logic [31:0]        w_hold_run;
    logic [1:0]         w_next_idx;
    logic signed [15:0] w_next_point;

    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_zero <= '0;
            r_point_one  <= '0;
            r_point_two  <= '0;
            r_slew_step  <= '0;
            r_timeout    <= sss_pkg::TIMEOUT_RESET;
            r_err_limit  <= '0;
            r_spd_limit  <= '0;
            r_hold_time  <= '0;
        end else if (w_cfg_wr) begin
            case (sss_pkg::t_reg_idx'(paddr[4:2]))
                sss_pkg::REG_POINT_ZERO: r_point_zero <= pwdata[15:0];
                sss_pkg::REG_POINT_ONE:  r_point_one  <= pwdata[15:0];
                sss_pkg::REG_POINT_TWO:  r_point_two  <= pwdata[15:0];
                sss_pkg::REG_SLEW_STEP:  r_slew_step  <= pwdata[14:0];
                sss_pkg::REG_TIMEOUT:    r_timeout    <= pwdata;
                sss_pkg::REG_ERR_LIMIT:  r_err_limit  <= pwdata[15:0];
                sss_pkg::REG_SPD_LIMIT:  r_spd_limit  <= pwdata[18:0];
                sss_pkg::REG_HOLD_TIME:  r_hold_time  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sss_pkg::t_reg_idx'(paddr[4:2]))
            sss_pkg::REG_POINT_ZERO: prdata = {16'd0, r_point_zero};
            sss_pkg::REG_POINT_ONE:  prdata = {16'd0, r_point_one};
            sss_pkg::REG_POINT_TWO:  prdata = {16'd0, r_point_two};
            sss_pkg::REG_SLEW_STEP:  prdata = {17'd0, r_slew_step};
            sss_pkg::REG_TIMEOUT:    prdata = r_timeout;
            sss_pkg::REG_ERR_LIMIT:  prdata = {16'd0, r_err_limit};
            sss_pkg::REG_SPD_LIMIT:  prdata = {13'd0, r_spd_limit};
            sss_pkg::REG_HOLD_TIME:  prdata = r_hold_time;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_cmd        <= sss_pkg::t_cmd'(i_s_tuser[1:0]);
            r_meas_valid <= i_s_tuser[2];
            r_now        <= i_s_tdata[31:0];
            r_pos        <= i_s_tdata[47:32];
            r_spd        <= i_s_tdata[67:48];
        end
    end

    // Slew and settle arithmetic.
    always_comb begin
        w_diff     = {r_dest[15], r_dest} - {r_ref[15], r_ref};
        w_step     = {2'b00, r_slew_step};
        w_arrived  = 1'b1;
        w_slewed   = r_dest;
        if (r_slew_step != '0) begin
            if (w_diff > w_step) begin
                w_arrived = 1'b0;
                w_slewed  = r_ref + {1'b0, r_slew_step};
            end else if (w_diff < -w_step) begin
                w_arrived = 1'b0;
                w_slewed  = r_ref - {1'b0, r_slew_step};
            end
        end
        w_err      = {r_dest[15], r_dest} - {r_pos[15], r_pos};
        w_abs_err  = w_err[16] ? 17'(-w_err) : 17'(w_err);
        w_abs_spd  = r_spd[19] ? 20'(-r_spd) : 20'(r_spd);
        w_run_time = r_now - r_start;
        w_hold_run = r_now - r_settle;
        w_next_idx = r_idx + 2'd1;
        case (w_next_idx)
            2'd0:    w_next_point = r_point_zero;
            2'd1:    w_next_point = r_point_one;
            default: w_next_point = r_point_two;
        endcase
    end

    // Next state.
    always_comb begin
        n_mode     = r_mode;
        n_idx      = r_idx;
        n_dest     = r_dest;
        n_ref      = r_ref;
        n_start    = r_start;
        n_elapsed  = r_elapsed;
        n_settle   = r_settle;
        n_settling = r_settling;
        case (r_cmd)
            sss_pkg::CMD_TICK: begin
                if (r_mode == sss_pkg::MODE_RUN) begin
                    n_elapsed = w_run_time;
                    if (w_run_time >= r_timeout) begin
                        n_mode     = sss_pkg::MODE_TIMEOUT;
                        n_settling = 1'b0;
                    end else if (!r_meas_valid) begin
                        n_settling = 1'b0;
                    end else begin
                        n_ref = w_slewed;
                        if (!w_arrived) begin
                            n_settling = 1'b0;
                        end else if (w_abs_err > {1'b0, r_err_limit}
                                     || w_abs_spd > {1'b0, r_spd_limit}) begin
                            n_settling = 1'b0;
                        end else if (!r_settling) begin
                            n_settle   = r_now;
                            n_settling = 1'b1;
                        end else if (w_hold_run >= r_hold_time) begin
                            n_settling = 1'b0;
                            if (32'(w_next_idx) < sss_pkg::POINT_COUNT) begin
                                n_idx  = w_next_idx;
                                n_dest = w_next_point;
                            end else begin
                                n_mode = sss_pkg::MODE_DONE;
                            end
                        end
                    end
                end
            end
            sss_pkg::CMD_START: begin
                n_mode     = sss_pkg::MODE_RUN;
                n_idx      = 2'd1;
                n_dest     = r_point_one;
                n_ref      = r_point_zero;
                n_start    = r_now;
                n_elapsed  = '0;
                n_settle   = '0;
                n_settling = 1'b0;
            end
            sss_pkg::CMD_IDLE: begin
                n_mode     = sss_pkg::MODE_IDLE;
                n_settling = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= sss_pkg::MODE_IDLE;
            r_idx      <= '0;
            r_dest     <= '0;
            r_ref      <= '0;
            r_start    <= '0;
            r_elapsed  <= '0;
            r_settle   <= '0;
            r_settling <= 1'b0;
        end else if (r_in_valid && w_advance) begin
            r_mode     <= n_mode;
            r_idx      <= n_idx;
            r_dest     <= n_dest;
            r_ref      <= n_ref;
            r_start    <= n_start;
            r_elapsed  <= n_elapsed;
            r_settle   <= n_settle;
            r_settling <= n_settling;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_advance) begin
            r_out_data <= {4'd0, n_elapsed, n_dest, n_ref, n_idx, n_mode};
        end
    end

    a_settling_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settling |-> r_mode == sss_pkg::MODE_RUN)
        else $error("settling flag set outside the running state");

    a_index_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != sss_pkg::MODE_IDLE |-> (r_idx == 2'd1 || r_idx == 2'd2))
        else $error("step index out of range after a start");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == sss_pkg::MODE_DONE |-> r_idx == 2'd2)
        else $error("sequence complete before the last point");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_now) && $stable(r_cmd))
        else $error("input register lost a beat while the result side stalled");

endmodule

`default_nettype wire
